>>> rtl/swm_pkg.sv
// Package for the sliding-window median filter.
// Holds the configuration register width and reset value; no dependencies.
package swm_pkg;

  // Width and reset value of the window size register.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  // Handshake summary passed to the checker.
  typedef struct packed {
    logic in_take;
    logic out_take;
    logic cfg_take;
  } swm_xfer_t;

endpackage

>>> rtl/sliding_window_median.sv
// Sliding-window median filter: sorted row of compare-and-shift cells; depends on swm_pkg.
// An accepted sample enters the cell row; the result register then takes its median.
// Throughput: one sample per cycle; in_stall rises only while out_stall holds a result
// and the cell row already holds the next one.
// Reset (synchronous, rst high) empties the window and sets window_size to 3.
// A write of window_size also empties the window.
module sliding_window_median #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]      window_size,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           ends_sequence,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] median
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // Configuration and window state.
  logic [swm_pkg::CFG_W-1:0]      ws;
  logic signed [SAMPLE_WIDTH-1:0] cell_key [WINDOW_MAX];
  logic [AW-1:0]                  cell_age [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          cell_valid;
  logic [CW-1:0]                  fill_count;
  logic                           res_pending;

  // Next-state values of the cell row.
  logic signed [SAMPLE_WIDTH-1:0] key_next [WINDOW_MAX];
  logic [AW-1:0]                  age_next [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          valid_next;
  logic [CW-1:0]                  fill_count_next;
  logic                           produced;

  // Row after removal of the oldest sample.
  logic signed [SAMPLE_WIDTH-1:0] c_key [WINDOW_MAX];
  logic [AW-1:0]                  c_age [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          c_valid;
  logic [WINDOW_MAX-1:0]          c_le;
  logic [WINDOW_MAX-1:0]          le;
  logic [WINDOW_MAX-1:0]          rem;
  logic [WINDOW_MAX-1:0]          pre;

  logic [CW-1:0] w;
  logic [CW-1:0] mid;
  logic          full;
  logic          accept;
  logic          move;

  // Effective window length: zero acts as one, oversize clamps to capacity.
  always_comb begin
    if (ws == '0) begin
      w = CW'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      w = CW'(WINDOW_MAX);
    end else begin
      w = CW'(ws);
    end
  end

  assign mid  = (w - CW'(1)) >> 1;
  assign full = (fill_count == w);

  // Handshakes: the result register frees the cell row for the next sample.
  assign cfg_ready = 1'b1;
  assign move      = res_pending && (!out_valid || !out_stall);
  assign in_stall  = res_pending && !move;
  assign accept    = in_valid && !in_stall;

  // Per-cell flags: oldest sample when full, and order against the new sample.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      rem[i] = full && cell_valid[i] && (CW'(cell_age[i]) == (w - CW'(1)));
      le[i]  = cell_valid[i] && (cell_key[i] <= sample);
    end
  end

  // Each cell learns whether the removed sample sits at or below it.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      pre[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        pre[i] = pre[i] | rem[j];
      end
    end
  end

  // Close the gap left by the removed sample.
  always_comb begin
    int nx;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      nx = (i < WINDOW_MAX - 1) ? i + 1 : i;
      if (pre[i] && i < WINDOW_MAX - 1) begin
        c_key[i]   = cell_key[nx];
        c_age[i]   = cell_age[nx];
        c_valid[i] = cell_valid[nx];
        c_le[i]    = le[nx];
      end else if (pre[i]) begin
        c_key[i]   = cell_key[i];
        c_age[i]   = cell_age[i];
        c_valid[i] = 1'b0;
        c_le[i]    = 1'b0;
      end else begin
        c_key[i]   = cell_key[i];
        c_age[i]   = cell_age[i];
        c_valid[i] = cell_valid[i];
        c_le[i]    = le[i];
      end
    end
  end

  // Insert the new sample after every kept sample that is not greater.
  always_comb begin
    int  pv;
    logic prev_le;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      pv      = (i > 0) ? i - 1 : 0;
      prev_le = (i == 0) ? 1'b1 : c_le[pv];
      if (c_le[i]) begin
        key_next[i] = c_key[i];
        age_next[i] = c_age[i] + AW'(1);
      end else if (prev_le) begin
        key_next[i] = sample;
        age_next[i] = '0;
      end else begin
        key_next[i] = c_key[pv];
        age_next[i] = c_age[pv] + AW'(1);
      end
      valid_next[i] = c_valid[i] || (i == 0) || c_valid[pv];
    end
    fill_count_next = full ? fill_count : fill_count + CW'(1);
    produced        = (fill_count_next == w);
  end

  // Cell row payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        cell_key[i] <= key_next[i];
        cell_age[i] <= age_next[i];
      end
    end
  end

  // Window control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws          <= swm_pkg::WINDOW_SIZE_RESET;
      fill_count  <= '0;
      cell_valid  <= '0;
      res_pending <= 1'b0;
    end else begin
      if (accept) begin
        res_pending <= produced;
        if (ends_sequence) begin
          fill_count <= '0;
          cell_valid <= '0;
        end else begin
          fill_count <= fill_count_next;
          cell_valid <= valid_next;
        end
      end else if (move) begin
        res_pending <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        ws         <= window_size;
        fill_count <= '0;
        cell_valid <= '0;
      end
    end
  end

  // Result register: picks the lower median from the settled row.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      median <= cell_key[mid[AW-1:0]];
    end
  end

endmodule

>>> rtl/swm_checker.sv
// Port-level checker for the sliding-window median filter, with its bind.
// Depends on swm_pkg and attaches to sliding_window_median.
module swm_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [swm_pkg::CFG_W-1:0]      window_size,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample,
  input logic                           ends_sequence,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH-1:0] median
);

  swm_pkg::swm_xfer_t xfer;

  assign xfer.in_take  = in_valid && !in_stall;
  assign xfer.out_take = out_valid && !out_stall;
  assign xfer.cfg_take = cfg_valid && cfg_ready;

  // A stalled input transaction holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sample) && $stable(ends_sequence))
    else $error("input transaction changed while stalled");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median))
    else $error("result changed while stalled");

  // Reset leaves no result on the output.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A fresh result traces back through the result register and the cell row to an accepted sample.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(xfer.in_take, 2))
    else $error("result without an accepted sample");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_swm_checker (.*);
